FILE: rtl/touch_gesture_recognizer_top_assert.svh
// Assertion macros shared by the RTL; all are disabled while reset is held.
`ifndef TOUCH_GESTURE_RECOGNIZER_TOP_ASSERT_SVH
`define TOUCH_GESTURE_RECOGNIZER_TOP_ASSERT_SVH

// Same-cycle implication.
`define TGR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");

// Next-cycle implication.
`define TGR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`endif

FILE: rtl/tgr_pkg.sv
package tgr_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_HALF_WIDTH     = 3'd0,
        REG_MOVE_TOL       = 3'd1,
        REG_HOLD_TICKS     = 3'd2,
        REG_TOP_ZONE_END_Y = 3'd3,
        REG_SCROLL_START_Y = 3'd4,
        REG_SELECT_END_X   = 3'd5,
        REG_SCROLL_LIMIT   = 3'd6
    } t_reg_idx;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_LEFT_HOLD = 3'd1,
        EV_LEFT_TAP  = 3'd2,
        EV_MENU_TAP  = 3'd3,
        EV_LIST_TAP  = 3'd4
    } t_event;

    localparam logic [11:0] HALF_WIDTH_RST     = 12'd240;
    localparam logic [11:0] MOVE_TOL_RST       = 12'd20;
    localparam logic [15:0] HOLD_TICKS_RST     = 16'd500;
    localparam logic [11:0] TOP_ZONE_END_Y_RST = 12'd66;
    localparam logic [11:0] SCROLL_START_Y_RST = 12'd98;
    localparam logic [11:0] SELECT_END_X_RST   = 12'd64;
    localparam logic [19:0] SCROLL_LIMIT_RST   = 20'd0;
    localparam logic [19:0] SCROLL_SAT         = 20'hFFFFF;

    typedef struct packed {
        logic [11:0] half_width;
        logic [11:0] move_tolerance;
        logic [15:0] hold_ticks;
        logic [11:0] top_zone_end_y;
        logic [11:0] scroll_zone_start_y;
        logic [11:0] select_zone_end_x;
        logic [19:0] scroll_limit;
    } t_cfg;

    typedef struct packed {
        logic        read_ok;
        logic [3:0]  point_count;
        logic [11:0] raw_x;
        logic [11:0] raw_y;
        logic        menu_is_open;
        logic        list_is_open;
        logic [31:0] now_tick;
    } t_sample;

    typedef struct packed {
        logic        touching;
        logic [11:0] touch_x;
        logic [11:0] touch_y;
        t_event      event_code;
        logic [11:0] event_x;
        logic [11:0] event_y;
        logic [19:0] scroll_offset;
        logic        render_notify;
    } t_result;

endpackage

FILE: rtl/tgr_cfg.sv
module tgr_cfg (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_wr_en,
    input  logic [2:0]              i_wr_index,
    input  logic [31:0]             i_wr_data,
    output tgr_pkg::t_cfg           o_cfg
);

    tgr_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_width          <= tgr_pkg::HALF_WIDTH_RST;
            r_cfg.move_tolerance      <= tgr_pkg::MOVE_TOL_RST;
            r_cfg.hold_ticks          <= tgr_pkg::HOLD_TICKS_RST;
            r_cfg.top_zone_end_y      <= tgr_pkg::TOP_ZONE_END_Y_RST;
            r_cfg.scroll_zone_start_y <= tgr_pkg::SCROLL_START_Y_RST;
            r_cfg.select_zone_end_x   <= tgr_pkg::SELECT_END_X_RST;
            r_cfg.scroll_limit        <= tgr_pkg::SCROLL_LIMIT_RST;
        end else if (i_wr_en) begin
            case (tgr_pkg::t_reg_idx'(i_wr_index))
                tgr_pkg::REG_HALF_WIDTH:     r_cfg.half_width          <= i_wr_data[11:0];
                tgr_pkg::REG_MOVE_TOL:       r_cfg.move_tolerance      <= i_wr_data[11:0];
                tgr_pkg::REG_HOLD_TICKS:     r_cfg.hold_ticks          <= i_wr_data[15:0];
                tgr_pkg::REG_TOP_ZONE_END_Y: r_cfg.top_zone_end_y      <= i_wr_data[11:0];
                tgr_pkg::REG_SCROLL_START_Y: r_cfg.scroll_zone_start_y <= i_wr_data[11:0];
                tgr_pkg::REG_SELECT_END_X:   r_cfg.select_zone_end_x   <= i_wr_data[11:0];
                tgr_pkg::REG_SCROLL_LIMIT:   r_cfg.scroll_limit        <= i_wr_data[19:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/tgr_gesture.sv
module tgr_gesture (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  tgr_pkg::t_cfg           i_cfg,
    input  tgr_pkg::t_sample        i_sample,
    output tgr_pkg::t_result        o_result
);

    logic        r_prev_touching, n_prev_touching;
    logic [11:0] r_prev_x, n_prev_x;
    logic [11:0] r_prev_y, n_prev_y;
    logic        r_left_tracking, n_left_tracking;
    logic        r_hold_done, n_hold_done;
    logic        r_menu_from_hold, n_menu_from_hold;
    logic [11:0] r_press_x, n_press_x;
    logic [11:0] r_press_y, n_press_y;
    logic [31:0] r_press_tick, n_press_tick;
    logic [11:0] r_drag_last_y, n_drag_last_y;
    logic        r_list_scrolling, n_list_scrolling;
    logic        r_list_dragged, n_list_dragged;
    logic [19:0] r_scroll_value, n_scroll_value;

    logic        touching;
    logic [11:0] cur_x;
    logic [11:0] cur_y;
    logic [12:0] delta;
    logic [21:0] scroll_sum;
    logic [11:0] dx;
    logic [11:0] dy;
    logic [31:0] elapsed;
    logic        list_top;
    logic        list_sel;
    tgr_pkg::t_result res;

    always_comb begin
        touching = i_sample.read_ok && (i_sample.point_count != 4'd0);
        cur_x    = touching ? i_sample.raw_x : 12'd0;
        cur_y    = touching ? i_sample.raw_y : 12'd0;

        n_left_tracking  = r_left_tracking;
        n_hold_done      = r_hold_done;
        n_menu_from_hold = r_menu_from_hold;
        n_press_x        = r_press_x;
        n_press_y        = r_press_y;
        n_press_tick     = r_press_tick;
        n_drag_last_y    = r_drag_last_y;
        n_list_scrolling = r_list_scrolling;
        n_list_dragged   = r_list_dragged;
        n_scroll_value   = r_scroll_value;

        res               = '0;
        res.touching      = touching;
        res.touch_x       = cur_x;
        res.touch_y       = cur_y;
        res.event_code    = tgr_pkg::EV_NONE;

        // press edge; menu wins over list
        if (touching && !r_prev_touching) begin
            n_menu_from_hold = 1'b0;
            if (i_sample.menu_is_open) begin
                n_left_tracking = 1'b0;
                n_hold_done     = 1'b1;
            end else if (i_sample.list_is_open) begin
                n_left_tracking  = 1'b0;
                n_hold_done      = 1'b1;
                n_list_scrolling = (cur_y >= i_cfg.scroll_zone_start_y) &&
                                   (cur_x > i_cfg.select_zone_end_x);
                n_list_dragged   = 1'b0;
                n_drag_last_y    = cur_y;
            end else begin
                n_left_tracking = cur_x < i_cfg.half_width;
                n_hold_done     = 1'b0;
            end
            n_press_x    = cur_x;
            n_press_y    = cur_y;
            n_press_tick = i_sample.now_tick;
        end

        // drag: offset goes against finger, clamped 0..limit (0xFFFFF if 0)
        delta      = {1'b0, cur_y} - {1'b0, n_drag_last_y};
        scroll_sum = {2'b00, r_scroll_value} - {{9{delta[12]}}, delta};
        if (touching && n_list_scrolling) begin
            if (delta != 13'd0)
                n_list_dragged = 1'b1;
            if (scroll_sum[21])
                n_scroll_value = 20'd0;
            else if (i_cfg.scroll_limit != 20'd0) begin
                if (scroll_sum[20:0] > {1'b0, i_cfg.scroll_limit})
                    n_scroll_value = i_cfg.scroll_limit;
                else
                    n_scroll_value = scroll_sum[19:0];
            end else if (scroll_sum[20])
                n_scroll_value = tgr_pkg::SCROLL_SAT;
            else
                n_scroll_value = scroll_sum[19:0];
            n_drag_last_y     = cur_y;
            res.render_notify = 1'b1;
        end

        dx      = (cur_x >= n_press_x) ? (cur_x - n_press_x) : (n_press_x - cur_x);
        dy      = (cur_y >= n_press_y) ? (cur_y - n_press_y) : (n_press_y - cur_y);
        elapsed = i_sample.now_tick - n_press_tick;
        if (touching && n_left_tracking) begin
            if (cur_x >= i_cfg.half_width)
                n_left_tracking = 1'b0;
            else if ((dx > i_cfg.move_tolerance) || (dy > i_cfg.move_tolerance))
                n_left_tracking = 1'b0;
            else if (!n_hold_done && (elapsed >= {16'd0, i_cfg.hold_ticks})) begin
                res.event_code   = tgr_pkg::EV_LEFT_HOLD;
                res.event_x      = cur_x;
                res.event_y      = cur_y;
                n_hold_done      = 1'b1;
                n_menu_from_hold = 1'b1;
            end
        end

        // release edge; list wins over menu, reported at the last position
        list_top = r_prev_y < i_cfg.top_zone_end_y;
        list_sel = (r_prev_y >= i_cfg.scroll_zone_start_y) &&
                   (r_prev_x <= i_cfg.select_zone_end_x);
        if (!touching && r_prev_touching) begin
            n_list_scrolling = 1'b0;
            if (i_sample.list_is_open) begin
                if ((list_top || list_sel) && !n_list_dragged) begin
                    res.event_code = tgr_pkg::EV_LIST_TAP;
                    res.event_x    = r_prev_x;
                    res.event_y    = r_prev_y;
                end
            end else if (i_sample.menu_is_open) begin
                if (n_menu_from_hold)
                    n_menu_from_hold = 1'b0;
                else begin
                    res.event_code = tgr_pkg::EV_MENU_TAP;
                    res.event_x    = r_prev_x;
                    res.event_y    = r_prev_y;
                end
            end else if (n_left_tracking && !n_hold_done) begin
                res.event_code = tgr_pkg::EV_LEFT_TAP;
                res.event_x    = r_prev_x;
                res.event_y    = r_prev_y;
            end
            n_left_tracking = 1'b0;
            n_hold_done     = 1'b0;
        end

        if ((touching != r_prev_touching) ||
            (touching && ((cur_x != r_prev_x) || (cur_y != r_prev_y))))
            res.render_notify = 1'b1;

        res.scroll_offset = n_scroll_value;
        n_prev_touching   = touching;
        n_prev_x          = cur_x;
        n_prev_y          = cur_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_touching  <= 1'b0;
            r_prev_x         <= '0;
            r_prev_y         <= '0;
            r_left_tracking  <= 1'b0;
            r_hold_done      <= 1'b0;
            r_menu_from_hold <= 1'b0;
            r_press_x        <= '0;
            r_press_y        <= '0;
            r_press_tick     <= '0;
            r_drag_last_y    <= '0;
            r_list_scrolling <= 1'b0;
            r_list_dragged   <= 1'b0;
            r_scroll_value   <= '0;
        end else if (i_step) begin
            r_prev_touching  <= n_prev_touching;
            r_prev_x         <= n_prev_x;
            r_prev_y         <= n_prev_y;
            r_left_tracking  <= n_left_tracking;
            r_hold_done      <= n_hold_done;
            r_menu_from_hold <= n_menu_from_hold;
            r_press_x        <= n_press_x;
            r_press_y        <= n_press_y;
            r_press_tick     <= n_press_tick;
            r_drag_last_y    <= n_drag_last_y;
            r_list_scrolling <= n_list_scrolling;
            r_list_dragged   <= n_list_dragged;
            r_scroll_value   <= n_scroll_value;
        end
    end

    assign o_result = res;

endmodule

FILE: rtl/touch_gesture_recognizer_top.sv
// Touch gesture recogniser: one poll sample in, one result word out. A sample
// is registered on accept, processed against the tracking state and lands in
// the result register; a new sample can be taken every cycle while the result
// register is free or draining, and the per-sample state update is the only
// loop. The input register can take one more sample while a result waits.
// Config writes are always accepted and must only be issued while the block
// is idle.
`include "touch_gesture_recognizer_top_assert.svh"

module touch_gesture_recognizer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_read_ok,
    input  logic [3:0]  i_point_count,
    input  logic [11:0] i_raw_x,
    input  logic [11:0] i_raw_y,
    input  logic        i_menu_is_open,
    input  logic        i_list_is_open,
    input  logic [31:0] i_now_tick,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_touching,
    output logic [11:0] o_touch_x,
    output logic [11:0] o_touch_y,
    output logic [2:0]  o_event_code,
    output logic [11:0] o_event_x,
    output logic [11:0] o_event_y,
    output logic [19:0] o_scroll_offset,
    output logic        o_render_notify
);

    tgr_pkg::t_cfg    cfg;
    tgr_pkg::t_sample r_sample;
    tgr_pkg::t_result result;
    tgr_pkg::t_result r_result;
    logic             r_in_vld;
    logic             r_out_vld;
    logic             step;
    logic             out_idle;
    logic             out_no_event;
    logic             out_hold_ev;

    assign o_cfg_ready = 1'b1;

    tgr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // the held sample moves on when the result register is free or draining
    assign step       = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_sample.read_ok      <= i_read_ok;
            r_sample.point_count  <= i_point_count;
            r_sample.raw_x        <= i_raw_x;
            r_sample.raw_y        <= i_raw_y;
            r_sample.menu_is_open <= i_menu_is_open;
            r_sample.list_is_open <= i_list_is_open;
            r_sample.now_tick     <= i_now_tick;
        end
    end

    tgr_gesture u_gesture (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_cfg    (cfg),
        .i_sample (r_sample),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_result <= result;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_touching      = r_result.touching;
    assign o_touch_x       = r_result.touch_x;
    assign o_touch_y       = r_result.touch_y;
    assign o_event_code    = r_result.event_code;
    assign o_event_x       = r_result.event_x;
    assign o_event_y       = r_result.event_y;
    assign o_scroll_offset = r_result.scroll_offset;
    assign o_render_notify = r_result.render_notify;

    assign out_idle     = o_out_valid && !o_touching;
    assign out_no_event = o_out_valid && (o_event_code == tgr_pkg::EV_NONE);
    assign out_hold_ev  = o_out_valid && (o_event_code == tgr_pkg::EV_LEFT_HOLD);

    `TGR_ASSERT_NEXT(a_step_fills_out, i_clk, i_rst_n, step, o_out_valid)
    `TGR_ASSERT_IMPL(a_idle_pos_zero, i_clk, i_rst_n, out_idle, (o_touch_x | o_touch_y) == 12'd0)
    `TGR_ASSERT_IMPL(a_no_event_pos_zero, i_clk, i_rst_n, out_no_event, (o_event_x | o_event_y) == 12'd0)
    `TGR_ASSERT_IMPL(a_hold_while_touching, i_clk, i_rst_n, out_hold_ev, o_touching)

endmodule
